// ===== sv/decimal_field_formatter_defines.svh =====
// assertion macros for the decimal field formatter
// no dependencies; included by dfmt_front, the module that carries assertions
`ifndef DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define DECIMAL_FIELD_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

`define DFMT_ASSERT_PROP(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("property violated");

`define DFMT_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`else

`define DFMT_ASSERT_PROP(label, clk, rstn, prop)

`define DFMT_ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// ===== sv/dfmt_pkg.sv =====
// types, character codes and decade tables for the decimal field formatter
// no dependencies
`default_nettype none

package dfmt_pkg;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  localparam int unsigned NUM_DIGITS = 10;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_PUSH
  } fe_state_e;

  // one converted number waiting to be printed
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [3:0]                 nd;
    logic                       neg;
    logic                       zpad;
    logic [5:0]                 pads;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [9:0][33:0]  mult_row_t;
  typedef mult_row_t [NUM_DIGITS-1:0] mult_tab_t;

  // entry [i][k] holds k * 10**i
  function automatic mult_tab_t build_mult_tab();
    mult_tab_t   t;
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      for (int k = 0; k < 10; k++) begin
        t[i][k] = 34'(p * 64'(k));
      end
      p = p * 64'd10;
    end
    return t;
  endfunction

  localparam mult_tab_t DEC_MULT = build_mult_tab();

endpackage

`default_nettype wire

// ===== sv/dfmt_in_if.sv =====
// request channel carrying one number and its format
// no dependencies
`default_nettype none

interface dfmt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [5:0]  field_width;
  logic        zero_pad;
  logic        unsigned_mode;

  modport source (output valid, value, field_width, zero_pad, unsigned_mode, input ready);
  modport sink   (input valid, value, field_width, zero_pad, unsigned_mode, output ready);
endinterface

`default_nettype wire

// ===== sv/dfmt_out_if.sv =====
// request channel carrying one output character
// no dependencies
`default_nettype none

interface dfmt_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

`default_nettype wire

// ===== sv/dfmt_front.sv =====
// front end: takes a request, forms the magnitude, extracts decimal digits
// one decade per cycle; depends on dfmt_pkg, dfmt_in_if and the defines header
`default_nettype none
`include "decimal_field_formatter_defines.svh"

module dfmt_front #(
  parameter int unsigned MAX_FIELD_WIDTH = 63
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  dfmt_in_if.sink              in_i,
  input  wire dfmt_pkg::q_stat_t stat_i,
  output logic                 push_o,
  output dfmt_pkg::desc_t      desc_o
);
  import dfmt_pkg::*;

  fe_state_e state_q, state_d;
  logic [3:0] pos_q;
  logic [3:0] nd_q;
  logic [31:0] mag_q;
  logic [NUM_DIGITS-1:0][3:0] dig_q;
  logic neg_q, zpad_q;
  logic [5:0] width_q;

  logic load, step, in_ready;
  logic [3:0] digit;
  logic [31:0] sub;
  logic in_neg;
  logic [31:0] in_mag;
  logic [5:0] in_width;
  logic [3:0] nd_fix;
  logic [4:0] body;
  logic [5:0] pads;

  assign in_neg   = !in_i.unsigned_mode && in_i.value[31];
  assign in_mag   = in_neg ? (32'd0 - in_i.value) : in_i.value;
  assign in_width = (in_i.field_width > 6'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH)
                                                            : in_i.field_width;

  // digit of the current decade by comparing against its multiples
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({2'b00, mag_q} >= DEC_MULT[pos_q][k]) begin
        digit = 4'(k);
      end
    end
    sub = DEC_MULT[pos_q][digit][31:0];
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    load     = 1'b0;
    step     = 1'b0;
    push_o   = 1'b0;
    unique case (state_q)
      FE_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          load    = 1'b1;
          state_d = FE_CONV;
        end
      end
      FE_CONV: begin
        step = 1'b1;
        if (pos_q == 4'd0) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!stat_i.full) begin
          push_o  = 1'b1;
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      pos_q   <= 4'd0;
      nd_q    <= 4'd0;
    end else begin
      state_q <= state_d;
      if (load) begin
        pos_q <= 4'(NUM_DIGITS - 1);
        nd_q  <= 4'd0;
      end else if (step) begin
        pos_q <= pos_q - 4'd1;
        if (digit != 4'd0 || nd_q != 4'd0) begin
          nd_q <= nd_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mag_q   <= in_mag;
      neg_q   <= in_neg;
      zpad_q  <= in_i.zero_pad;
      width_q <= in_width;
    end else if (step) begin
      mag_q        <= mag_q - sub;
      dig_q[pos_q] <= digit;
    end
  end

  // zero prints as a single digit
  assign nd_fix = (nd_q == 4'd0) ? 4'd1 : nd_q;
  assign body   = {1'b0, nd_fix} + {4'd0, neg_q};
  assign pads   = (width_q > {1'b0, body}) ? (width_q - {1'b0, body}) : 6'd0;

  always_comb begin
    desc_o.digits = dig_q;
    desc_o.nd     = nd_fix;
    desc_o.neg    = neg_q;
    desc_o.zpad   = zpad_q;
    desc_o.pads   = pads;
  end

  `DFMT_ASSERT_NEVER(a_pos_range, clk_i, rst_ni, (state_q == FE_CONV) && (pos_q > 4'd9))
  `DFMT_ASSERT_NEVER(a_nd_range, clk_i, rst_ni, nd_q > 4'd10)
  `DFMT_ASSERT_PROP(a_push_nd, clk_i, rst_ni, push_o |-> (desc_o.nd != 4'd0) && (desc_o.nd <= 4'd10))
  `DFMT_ASSERT_PROP(a_load_conv, clk_i, rst_ni, load |=> (state_q == FE_CONV) && (pos_q == 4'd9))

endmodule

`default_nettype wire

// ===== sv/dfmt_queue.sv =====
// two-entry queue of converted numbers between front and back end
// depends on dfmt_pkg
`default_nettype none

module dfmt_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dfmt_pkg::desc_t   data_i,
  input  wire logic              pop_i,
  output dfmt_pkg::desc_t        data_o,
  output dfmt_pkg::q_stat_t      stat_o
);
  import dfmt_pkg::*;

  desc_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

endmodule

`default_nettype wire

// ===== sv/dfmt_back.sv =====
// back end: walks one converted number and emits its characters, one per cycle
// while out_o is ready; depends on dfmt_pkg and dfmt_out_if
`default_nettype none

module dfmt_back #(
  parameter int unsigned MAX_FIELD_WIDTH = 63
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dfmt_pkg::desc_t desc_i,
  input  wire dfmt_pkg::q_stat_t stat_i,
  output logic                 pop_o,
  dfmt_out_if.source           out_o
);
  import dfmt_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELD_WIDTH + 1);

  logic [CntW-1:0] pos_q;
  logic            valid_q;
  logic [6:0]      char_q;
  logic            last_q;

  logic       load, is_last;
  logic [6:0] pos7, lead, total, j;
  logic [3:0] idx;
  logic [3:0] dval;
  logic [6:0] ch;

  assign pos7  = 7'(pos_q);
  assign lead  = {1'b0, desc_i.pads} + {6'd0, desc_i.neg};
  assign total = lead + {3'd0, desc_i.nd};
  assign j     = pos7 - lead;
  assign idx   = 4'({3'd0, desc_i.nd} - 7'd1 - j);

  always_comb begin
    dval = 4'd0;
    if (idx < 4'(NUM_DIGITS)) begin
      dval = desc_i.digits[idx];
    end
    if (desc_i.zpad) begin
      if (desc_i.neg && pos7 == 7'd0) begin
        ch = CH_MINUS;
      end else if (pos7 < lead) begin
        ch = CH_ZERO;
      end else begin
        ch = CH_ZERO + {3'd0, dval};
      end
    end else begin
      if (pos7 < {1'b0, desc_i.pads}) begin
        ch = CH_SPACE;
      end else if (pos7 < lead) begin
        ch = CH_MINUS;
      end else begin
        ch = CH_ZERO + {3'd0, dval};
      end
    end
  end

  assign is_last = (pos7 == total - 7'd1);
  assign load    = !stat_i.empty && (!valid_q || out_o.ready);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        pos_q   <= is_last ? '0 : pos_q + 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.character = char_q;
  assign out_o.last_char = last_q;

endmodule

`default_nettype wire

// ===== sv/decimal_field_formatter.sv =====
// decimal field formatter: one 32-bit number in, padded ascii decimal characters out
// the front end converts one number at a time in ten digit steps; the two-entry
// queue lets it start the next number while the back end still emits characters,
// which leave at one per cycle while out_o is ready
// reset: asynchronous, clears the sequencer, queue pointers and output valid
// depends on dfmt_pkg, dfmt_in_if, dfmt_out_if, dfmt_front, dfmt_queue, dfmt_back
`default_nettype none

module decimal_field_formatter #(
  parameter int unsigned MAX_FIELD_WIDTH = 63
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dfmt_in_if.sink    in_i,
  dfmt_out_if.source out_o
);
  import dfmt_pkg::*;

  desc_t   fe_desc, q_desc;
  q_stat_t q_stat;
  logic    push, pop;

  dfmt_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .stat_i (q_stat),
    .push_o (push),
    .desc_o (fe_desc)
  );

  dfmt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fe_desc),
    .pop_i  (pop),
    .data_o (q_desc),
    .stat_o (q_stat)
  );

  dfmt_back #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .desc_i (q_desc),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
